// ===== src/lct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lct_pkg;

  // Field widths of the request and result items.
  localparam int OP_W       = 2;
  localparam int FRAME_W    = 3;
  localparam int LABEL_W    = 32;
  localparam int LIN_W      = 30;
  localparam int REG_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 31;
  localparam int SUM_W      = 40;
  localparam int CENT_W     = 18;
  localparam int CFG_IDX_W  = 2;

  // Widest label id and coordinate that any configuration can produce.
  localparam int LABEL_MAX_W = 16;
  localparam int COORD_MAX_W = 12;

  // Operations.
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN    = 2'd1;
  localparam logic [OP_W-1:0] OP_RELABEL = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LABEL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_MOVE   = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // Saturation limits.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [CENT_W-1:0]  CENT_MAX  = 18'h3_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FRAME_W-1:0] frame;
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] from_label;
    logic [LIN_W-1:0]   linear_index;
    logic               reverse_direction;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  voxel_count;
    logic [CENT_W-1:0]   centroid_z;
    logic [CENT_W-1:0]   centroid_y;
    logic [CENT_W-1:0]   centroid_x;
  } out_item_t;

  // Classified request: a zero source label means no removal, a zero
  // target label means no addition.
  typedef struct packed {
    logic [1:0]             kind;
    logic [STATUS_W-1:0]    status;
    logic [FRAME_W-1:0]     frame;
    logic [LABEL_MAX_W-1:0] src;
    logic [LABEL_MAX_W-1:0] dst;
    logic [COORD_MAX_W-1:0] z;
    logic [COORD_MAX_W-1:0] y;
    logic [COORD_MAX_W-1:0] x;
  } cmd_t;

  // One statistics table entry.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_z;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_x;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/lct_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lct_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== src/lct_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lct_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     data_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rptr_r];

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/lct_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lct_div #(
  parameter int NW = 30,
  parameter int DW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [NW-1:0] quot,
  output logic      [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {r_r, q_r[NW-1]};
  assign fits  = (trial >= {1'b0, d_r});
  assign diff  = trial - {1'b0, d_r};

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[NW-2:0], fits};
      r_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/lct_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lct_front
  import lct_pkg::*;
#(
  parameter int LABEL_BITS = 10,
  parameter int FRAMES     = 8,
  parameter int DIM_BITS   = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 hold,
  input  wire logic                 push,
  input  wire in_item_t             in_item,
  output logic                      full,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  output logic                      cmd_push,
  output cmd_t                      cmd_item,
  input  wire logic                 cmd_full
);

  localparam int XW  = DIM_BITS + 1;
  localparam int DVW = 2 * DIM_BITS + 1;
  localparam int PW  = 3 * DIM_BITS + 1;
  localparam int CW  = (PW > LIN_W) ? PW : LIN_W;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL1 = 3'd1;
  localparam logic [2:0] F_MUL2 = 3'd2;
  localparam logic [2:0] F_CHK  = 3'd3;
  localparam logic [2:0] F_DIV1 = 3'd4;
  localparam logic [2:0] F_DIV2 = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  // Register value clamped to 1 .. 2^DIM_BITS.
  function automatic logic [XW-1:0] dim_of(input logic [REG_W-1:0] r);
    int v;
    v = int'(r);
    if (v < 1) v = 1;
    if (v > (1 << DIM_BITS)) v = 1 << DIM_BITS;
    return XW'(v);
  endfunction

  logic [REG_W-1:0]      size_x_r;
  logic [REG_W-1:0]      size_y_r;
  logic [REG_W-1:0]      size_z_r;
  logic [XW-1:0]         sx;
  logic [XW-1:0]         sy;
  logic [XW-1:0]         sz;
  logic [DIM_BITS-1:0]   scan_x_r;
  logic [DIM_BITS-1:0]   scan_y_r;
  logic [DIM_BITS-1:0]   scan_z_r;
  logic [DIM_BITS-1:0]   scan_x_nxt;
  logic [DIM_BITS-1:0]   scan_y_nxt;
  logic [DIM_BITS-1:0]   scan_z_nxt;
  logic [2:0]            state_r;
  logic [LABEL_BITS-1:0] src_r;
  logic [LABEL_BITS-1:0] dst_r;
  logic [LIN_W-1:0]      lin_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [DVW-1:0]        p1_r;
  logic [PW-1:0]         p2_r;
  logic [DIM_BITS-1:0]   z_r;
  cmd_t                  cmd_r;
  cmd_t                  cmd_now;
  cmd_t                  cmd_chk;
  cmd_t                  cmd_mv;
  logic                  accept;
  logic                  go_seq;
  logic                  clr_scan;
  logic                  adv_scan;
  logic                  frame_ok;
  logic [LABEL_W-1:0]    sel_src;
  logic [LABEL_W-1:0]    sel_dst;
  logic                  src_in;
  logic                  dst_in;
  logic                  label_in;
  logic                  div_start;
  logic [LIN_W-1:0]      div_num;
  logic [DVW-1:0]        div_den;
  logic                  div_done;
  logic [LIN_W-1:0]      div_q;
  logic [DVW-1:0]        div_r;

  assign sx = dim_of(size_x_r);
  assign sy = dim_of(size_y_r);
  assign sz = dim_of(size_z_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= REG_W'(1024);
      size_y_r <= REG_W'(1024);
      size_z_r <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full   = hold || (state_r != F_IDLE) || cmd_full;
  assign accept = push && !full;

  assign frame_ok = (int'(in_item.frame) < FRAMES);
  assign sel_src  = in_item.reverse_direction ? in_item.label : in_item.from_label;
  assign sel_dst  = in_item.reverse_direction ? in_item.from_label : in_item.label;
  assign src_in   = (sel_src[LABEL_W-1:LABEL_BITS] == '0);
  assign dst_in   = (sel_dst[LABEL_W-1:LABEL_BITS] == '0);
  assign label_in = (in_item.label[LABEL_W-1:LABEL_BITS] == '0);

  // Classify the request; only relabel needs the sequencer.
  always_comb begin
    cmd_now        = '0;
    cmd_now.kind   = CMD_REPORT;
    cmd_now.status = ST_OK;
    cmd_now.frame  = in_item.frame;
    go_seq         = 1'b0;
    clr_scan       = 1'b0;
    adv_scan       = 1'b0;
    if (!frame_ok) begin
      cmd_now.status = ST_RANGE;
    end else begin
      case (in_item.operation)
        OP_CLEAR: begin
          cmd_now.kind = CMD_CLEAR;
          clr_scan     = 1'b1;
        end
        OP_SCAN: begin
          adv_scan = 1'b1;
          if (!label_in) begin
            cmd_now.status = ST_LABEL;
          end else if (in_item.label != '0) begin
            cmd_now.kind = CMD_MOVE;
            cmd_now.dst  = LABEL_MAX_W'(in_item.label[LABEL_BITS-1:0]);
            cmd_now.z    = COORD_MAX_W'(scan_z_r);
            cmd_now.y    = COORD_MAX_W'(scan_y_r);
            cmd_now.x    = COORD_MAX_W'(scan_x_r);
          end
        end
        OP_RELABEL: begin
          if (!src_in || !dst_in) begin
            cmd_now.status = ST_LABEL;
          end else begin
            go_seq = 1'b1;
          end
        end
        OP_QUERY: begin
          if (!label_in) begin
            cmd_now.status = ST_LABEL;
          end else begin
            cmd_now.kind = CMD_QUERY;
            cmd_now.dst  = LABEL_MAX_W'(in_item.label[LABEL_BITS-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // Raster position: x wraps into y, y into z, z to zero.
  always_comb begin
    scan_x_nxt = '0;
    scan_y_nxt = scan_y_r;
    scan_z_nxt = scan_z_r;
    if (XW'(scan_x_r) + XW'(1) < sx) begin
      scan_x_nxt = scan_x_r + DIM_BITS'(1);
    end else if (XW'(scan_y_r) + XW'(1) < sy) begin
      scan_y_nxt = scan_y_r + DIM_BITS'(1);
    end else begin
      scan_y_nxt = '0;
      scan_z_nxt = (XW'(scan_z_r) + XW'(1) < sz) ? scan_z_r + DIM_BITS'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r <= '0;
      scan_y_r <= '0;
      scan_z_r <= '0;
    end else if (accept && clr_scan) begin
      scan_x_r <= '0;
      scan_y_r <= '0;
      scan_z_r <= '0;
    end else if (accept && adv_scan) begin
      scan_x_r <= scan_x_nxt;
      scan_y_r <= scan_y_nxt;
      scan_z_r <= scan_z_nxt;
    end
  end

  // Relabel sequencer: volume size, range check, two divisions on a move.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: if (accept && go_seq) state_r <= F_MUL1;
        F_MUL1: state_r <= F_MUL2;
        F_MUL2: state_r <= F_CHK;
        F_CHK: begin
          if (CW'(lin_r) >= CW'(p2_r) || src_r == dst_r) begin
            state_r <= F_PUSH;
          end else begin
            state_r <= F_DIV1;
          end
        end
        F_DIV1: if (div_done) state_r <= F_DIV2;
        F_DIV2: if (div_done) state_r <= F_PUSH;
        F_PUSH: if (!cmd_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Requests that the sequencer hands on after the check or the divisions.
  always_comb begin
    cmd_chk        = '0;
    cmd_chk.kind   = CMD_REPORT;
    cmd_chk.frame  = frame_r;
    cmd_chk.status = (CW'(lin_r) >= CW'(p2_r)) ? ST_RANGE : ST_OK;
    cmd_mv         = '0;
    cmd_mv.kind    = CMD_MOVE;
    cmd_mv.status  = ST_OK;
    cmd_mv.frame   = frame_r;
    cmd_mv.src     = LABEL_MAX_W'(src_r);
    cmd_mv.dst     = LABEL_MAX_W'(dst_r);
    cmd_mv.z       = COORD_MAX_W'(z_r);
    cmd_mv.y       = COORD_MAX_W'(DIM_BITS'(div_q));
    cmd_mv.x       = COORD_MAX_W'(DIM_BITS'(div_r));
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && accept) begin
      src_r   <= sel_src[LABEL_BITS-1:0];
      dst_r   <= sel_dst[LABEL_BITS-1:0];
      lin_r   <= in_item.linear_index;
      frame_r <= in_item.frame;
    end
    if (state_r == F_MUL1) begin
      p1_r <= DVW'(sx) * DVW'(sy);
    end
    if (state_r == F_MUL2) begin
      p2_r <= PW'(p1_r) * PW'(sz);
    end
    if (state_r == F_CHK) begin
      cmd_r <= cmd_chk;
    end
    if (state_r == F_DIV1 && div_done) begin
      z_r <= DIM_BITS'(div_q);
    end
    if (state_r == F_DIV2 && div_done) begin
      cmd_r <= cmd_mv;
    end
  end

  // z = index / (X*Y); then y, x from the remainder divided by X.
  assign div_start = (state_r == F_CHK && CW'(lin_r) < CW'(p2_r) && src_r != dst_r)
                  || (state_r == F_DIV1 && div_done);
  assign div_num   = (state_r == F_CHK) ? lin_r : LIN_W'(div_r);
  assign div_den   = (state_r == F_CHK) ? p1_r : DVW'(sx);

  lct_div #(
    .NW(LIN_W),
    .DW(DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign cmd_push = (state_r == F_PUSH) ? !cmd_full : (accept && !go_seq);
  assign cmd_item = (state_r == F_PUSH) ? cmd_r : cmd_now;

endmodule

`default_nettype wire

// ===== src/lct_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lct_back
  import lct_pkg::*;
#(
  parameter int LABEL_BITS = 10,
  parameter int FRAMES     = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  output logic      init_busy,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd_item,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_push,
  output out_item_t res_item
);

  localparam int LABELS = 1 << LABEL_BITS;
  localparam int DEPTH  = FRAMES * LABELS;
  localparam int AW     = $clog2(DEPTH);
  localparam int EW     = $bits(entry_t);
  localparam int NW     = SUM_W + 8;

  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_CLR  = 3'd2;
  localparam logic [2:0] B_RM   = 3'd3;
  localparam logic [2:0] B_ADD  = 3'd4;
  localparam logic [2:0] B_QRD  = 3'd5;
  localparam logic [2:0] B_QDIV = 3'd6;

  function automatic logic [AW-1:0] addr_of(input logic [FRAME_W-1:0]     f,
                                            input logic [LABEL_MAX_W-1:0] lab);
    return AW'({f, lab[LABEL_BITS-1:0]});
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]       s,
                                               input logic [COORD_MAX_W-1:0] c);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(c);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] clamp_sub(input logic [SUM_W-1:0]       s,
                                                 input logic [COORD_MAX_W-1:0] c);
    return (s > SUM_W'(c)) ? s - SUM_W'(c) : '0;
  endfunction

  function automatic entry_t entry_add(input entry_t e, input cmd_t c);
    entry_t n;
    n       = e;
    n.sum_z = sat_add(e.sum_z, c.z);
    n.sum_y = sat_add(e.sum_y, c.y);
    n.sum_x = sat_add(e.sum_x, c.x);
    if (e.count < COUNT_MAX) n.count = e.count + COUNT_W'(1);
    return n;
  endfunction

  // A count that drops to zero empties the entry.
  function automatic entry_t entry_remove(input entry_t e, input cmd_t c);
    entry_t n;
    n = '0;
    if (e.count > COUNT_W'(1)) begin
      n.count = e.count - COUNT_W'(1);
      n.sum_z = clamp_sub(e.sum_z, c.z);
      n.sum_y = clamp_sub(e.sum_y, c.y);
      n.sum_x = clamp_sub(e.sum_x, c.x);
    end
    return n;
  endfunction

  function automatic logic [CENT_W-1:0] sat_cent(input logic [NW-1:0] q);
    return (q > NW'(CENT_MAX)) ? CENT_MAX : q[CENT_W-1:0];
  endfunction

  logic [2:0]        state_r;
  logic [AW-1:0]     ctr_r;
  cmd_t              cmd_r;
  entry_t            ent_r;
  logic [1:0]        qsel_r;
  logic [CENT_W-1:0] cz_r;
  logic [CENT_W-1:0] cy_r;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  entry_t            rd_ent;
  logic              take;
  logic              div_start;
  logic [NW-1:0]     div_num;
  logic              div_done;
  logic [NW-1:0]     div_q;
  logic [COUNT_W-1:0] div_r;

  assign rd_ent    = entry_t'(ram_rdata);
  assign init_busy = (state_r == B_INIT);
  assign take      = (state_r == B_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop   = take;

  // Memory access for the current step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(cmd_r.frame, cmd_r.dst);
    ram_wdata = '0;
    ram_raddr = addr_of(cmd_item.frame, cmd_item.dst);
    case (state_r)
      B_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ctr_r;
      end
      B_IDLE: begin
        if (cmd_item.kind == CMD_MOVE && cmd_item.src != '0) begin
          ram_raddr = addr_of(cmd_item.frame, cmd_item.src);
        end
      end
      B_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(cmd_r.frame, LABEL_MAX_W'(ctr_r[LABEL_BITS-1:0]));
      end
      B_RM: begin
        ram_we    = (rd_ent.count != '0);
        ram_waddr = addr_of(cmd_r.frame, cmd_r.src);
        ram_wdata = EW'(entry_remove(rd_ent, cmd_r));
        ram_raddr = addr_of(cmd_r.frame, cmd_r.dst);
      end
      B_ADD: begin
        ram_we    = 1'b1;
        ram_wdata = EW'(entry_add(rd_ent, cmd_r));
      end
      default: ;
    endcase
  end

  lct_ram #(
    .W(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result of the step that finishes a request.
  always_comb begin
    res_push        = 1'b0;
    res_item        = '0;
    res_item.status = ST_OK;
    case (state_r)
      B_IDLE: begin
        res_push        = take && (cmd_item.kind == CMD_REPORT);
        res_item.status = cmd_item.status;
      end
      B_CLR:  res_push = (ctr_r[LABEL_BITS-1:0] == '1);
      B_RM:   res_push = (cmd_r.dst == '0);
      B_ADD:  res_push = 1'b1;
      B_QRD: begin
        res_push        = (rd_ent.count == '0);
        res_item.status = ST_ABSENT;
      end
      B_QDIV: begin
        res_push = div_done && (qsel_r == 2'd2);
        res_item.voxel_count = ent_r.count;
        res_item.centroid_z  = cz_r;
        res_item.centroid_y  = cy_r;
        res_item.centroid_x  = sat_cent(div_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      ctr_r   <= '0;
    end else begin
      case (state_r)
        B_INIT: begin
          ctr_r <= ctr_r + AW'(1);
          if (ctr_r == AW'(DEPTH - 1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          ctr_r <= '0;
          if (take) begin
            case (cmd_item.kind)
              CMD_CLEAR: state_r <= B_CLR;
              CMD_MOVE:  state_r <= (cmd_item.src != '0) ? B_RM : B_ADD;
              CMD_QUERY: state_r <= B_QRD;
              default:   state_r <= B_IDLE;
            endcase
          end
        end
        B_CLR: begin
          ctr_r <= ctr_r + AW'(1);
          if (ctr_r[LABEL_BITS-1:0] == '1) state_r <= B_IDLE;
        end
        B_RM:   state_r <= (cmd_r.dst != '0) ? B_ADD : B_IDLE;
        B_ADD:  state_r <= B_IDLE;
        B_QRD:  state_r <= (rd_ent.count == '0) ? B_IDLE : B_QDIV;
        B_QDIV: if (div_done && qsel_r == 2'd2) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_item;
    end
    if (state_r == B_QRD) begin
      ent_r  <= rd_ent;
      qsel_r <= 2'd0;
    end
    if (state_r == B_QDIV && div_done) begin
      qsel_r <= qsel_r + 2'd1;
      if (qsel_r == 2'd0) cz_r <= sat_cent(div_q);
      if (qsel_r == 2'd1) cy_r <= sat_cent(div_q);
    end
  end

  // Centroid = sum * 256 / count, one axis at a time.
  assign div_start = (state_r == B_QRD && rd_ent.count != '0)
                  || (state_r == B_QDIV && div_done && qsel_r != 2'd2);
  always_comb begin
    if (state_r == B_QRD) begin
      div_num = {rd_ent.sum_z, 8'd0};
    end else if (qsel_r == 2'd0) begin
      div_num = {ent_r.sum_y, 8'd0};
    end else begin
      div_num = {ent_r.sum_x, 8'd0};
    end
  end

  lct_div #(
    .NW(NW),
    .DW(COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  ((state_r == B_QRD) ? rd_ent.count : ent_r.count),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // The remainder of the centroid division is not needed.
  logic unused_rem;
  assign unused_rem = ^div_r;

endmodule

`default_nettype wire

// ===== src/label_centroid_table.sv =====
// Per-frame label statistics table: count and z/y/x coordinate sums for
// each label id below 2^LABEL_BITS in each of FRAMES frames, held in one
// RAM of FRAMES * 2^LABEL_BITS entries. After reset a clearing pass writes
// every entry (8192 at the defaults), one per cycle, and full stays high
// meanwhile. A front part classifies requests, tracks the raster position
// and splits relabel indexes; a back part owns the RAM. A scan is a
// read-modify-write of one RAM entry. A clear writes the 2^LABEL_BITS
// entries of its frame, one entry per cycle. A relabel holds the front
// through the volume size and range check, two 30-step index divisions
// and the hand-off, then passes through the remove and add steps in the
// back. A relabel whose index is out of range or whose labels are equal
// stops after the range check. A query of a present label runs one division
// per axis in the bit-serial centroid divider. Requests with a label beyond
// the table are reported from the back's idle state without a RAM access.
`timescale 1ns / 1ps
`default_nettype none

module label_centroid_table
  import lct_pkg::*;
#(
  parameter int LABEL_BITS = 10,
  parameter int FRAMES     = 8,
  parameter int DIM_BITS   = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire in_item_t             in_item,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  logic      init_busy;
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  logic      cmd_pop;
  cmd_t      cmd_out;
  logic      cmd_empty;
  logic      res_push;
  out_item_t res_in;
  logic      res_full;

  lct_front #(
    .LABEL_BITS(LABEL_BITS),
    .FRAMES(FRAMES),
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (init_busy),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd_item  (cmd_in),
    .cmd_full  (cmd_full)
  );

  // Request queue between the front and the back.
  lct_fifo #(
    .W($bits(cmd_t)),
    .DEPTH(4)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  lct_back #(
    .LABEL_BITS(LABEL_BITS),
    .FRAMES(FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .cmd_empty (cmd_empty),
    .cmd_item  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  // Result queue toward the consumer.
  lct_fifo #(
    .W($bits(out_item_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule

`default_nettype wire
